// ===== design/si2u8_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// si2u8_pkg: shared types, constants and glyph tables for the script renderer.
// Holds the sizing of the decimal digit chain, the control word that steers
// each digit cell, the controller states and the UTF-8 glyph byte table.
// ----------------------------------------------------------------------------
package si2u8_pkg;

	// Number of low input bits taken as a two's complement value.
	localparam int VALUE_WIDTH = 64;
	// Decimal digits needed for the largest magnitude, 2**(VALUE_WIDTH-1).
	localparam int NUM_DIGITS = (VALUE_WIDTH * 302) / 1000 + 1;
	localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS + 1);
	localparam int BIT_CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

	// UTF-8 glyph bytes.
	localparam logic [7:0] BYTE_LEAD3 = 8'hE2;
	localparam logic [7:0] BYTE_LEAD2 = 8'hC2;
	localparam logic [7:0] BYTE_SUP_MID = 8'h81;
	localparam logic [7:0] BYTE_SUB_MID = 8'h82;
	localparam logic [7:0] BYTE_SUP_BASE = 8'hB0;
	localparam logic [7:0] BYTE_SUB_BASE = 8'h80;
	localparam logic [7:0] BYTE_SUP_ONE = 8'hB9;
	localparam logic [7:0] BYTE_SUP_MINUS = 8'hBB;
	localparam logic [7:0] BYTE_SUB_MINUS = 8'h8B;

	// Control word for the row of digit cells.
	typedef struct packed {
		logic clear;   // zero every digit
		logic dabble;  // adjust and shift in one binary bit
		logic advance; // move every digit one place toward the top
	} chain_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_SKIP,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	// Byte count of one glyph.
	function automatic logic [1:0] glyph_len(logic is_minus, logic [3:0] d, logic sup);
		logic [1:0] len;
		len = 2'd3;
		if (!is_minus && sup && (d == 4'd1 || d == 4'd2 || d == 4'd3)) begin
			len = 2'd2;
		end
		return len;
	endfunction

	// Byte at position pos of one glyph.
	function automatic logic [7:0] glyph_byte(logic is_minus, logic [3:0] d, logic sup,
			logic [1:0] pos);
		logic short_glyph;
		logic [7:0] b;
		short_glyph = !is_minus && sup && (d == 4'd1 || d == 4'd2 || d == 4'd3);
		case (pos)
			2'd0: begin
				b = short_glyph ? BYTE_LEAD2 : BYTE_LEAD3;
			end
			2'd1: begin
				if (short_glyph) begin
					b = (d == 4'd1) ? BYTE_SUP_ONE : (BYTE_SUP_BASE + {4'h0, d});
				end else begin
					b = sup ? BYTE_SUP_MID : BYTE_SUB_MID;
				end
			end
			2'd2: begin
				if (is_minus) begin
					b = sup ? BYTE_SUP_MINUS : BYTE_SUB_MINUS;
				end else begin
					b = sup ? (BYTE_SUP_BASE + {4'h0, d}) : (BYTE_SUB_BASE + {4'h0, d});
				end
			end
			default: begin
				b = BYTE_LEAD3;
			end
		endcase
		return b;
	endfunction

endpackage

// ===== design/si2u8_bcd_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// si2u8_bcd_cell: one decimal digit of the conversion chain.
// Adds three when the digit is five or more, then shifts in the bit from its
// lower neighbor; can also take over the lower neighbor's whole digit.
// ----------------------------------------------------------------------------
module si2u8_bcd_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  si2u8_pkg::chain_ctrl_t  ctrl,
	input  logic                    carry_in,
	input  logic [3:0]              digit_in,
	output logic                    carry_out,
	output logic [3:0]              digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	assign adj = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
	assign carry_out = adj[3];
	assign digit = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= 4'd0;
		end else if (ctrl.clear) begin
			digit_q <= 4'd0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[2:0], carry_in};
		end else if (ctrl.advance) begin
			digit_q <= digit_in;
		end
	end

endmodule

// ===== design/si2u8_digit_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// si2u8_digit_chain: row of decimal digit cells, least significant first.
// Binary bits enter at the bottom; the most significant digit leaves at the top.
// ----------------------------------------------------------------------------
module si2u8_digit_chain (
	input  logic                    clk,
	input  logic                    arst_n,
	input  si2u8_pkg::chain_ctrl_t  ctrl,
	input  logic                    bit_in,
	output logic [3:0]              top_digit
);

	localparam int ND = si2u8_pkg::NUM_DIGITS;

	logic [ND-1:0]   carry;
	logic [3:0]      digits [ND];

	genvar i;
	generate
		for (i = 0; i < ND; i++) begin : g_cell
			if (i == 0) begin : g_bottom
				si2u8_bcd_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.ctrl      (ctrl),
					.carry_in  (bit_in),
					.digit_in  (4'd0),
					.carry_out (carry[i]),
					.digit     (digits[i])
				);
			end else begin : g_upper
				si2u8_bcd_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.ctrl      (ctrl),
					.carry_in  (carry[i-1]),
					.digit_in  (digits[i-1]),
					.carry_out (carry[i]),
					.digit     (digits[i])
				);
			end
		end
	endgenerate

	// The top carry only ever leaves zero for in-range magnitudes.
	assign top_digit = (carry[ND-1] == 1'b0) ? digits[ND-1] : digits[ND-1];

endmodule

// ===== design/signed_int_to_utf8_script_digits.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_utf8_script_digits: renders a signed integer as UTF-8 bytes
// of Unicode subscript or superscript digits, one byte per output word.
//
// Input channel: in_valid / in_stall with value, use_superscript, show_zero.
// A word is taken when in_valid is high and in_stall is low. The block works
// on one word at a time and holds in_stall high until the last byte of the
// current word has been loaded into the output register.
// Output channel: out_valid / out_stall with out_byte and last; last marks the
// final byte of one value. A stalled output word holds steady.
// Steps: the magnitude is converted to decimal in a row of digit cells, one
// binary bit per cycle, for all VALUE_WIDTH bits (64). The leading zero scan
// then drops the zero digits one at a time (up to NUM_DIGITS-1) and stops on
// the first digit kept, and the bytes load at one per cycle while the output
// is not stalled, up to 60 for the most negative value, the longest word.
// Zero with show_zero low produces no byte and leaves the input free at once.
// Reset clears the controller and the output valid; no word is in flight.
// ----------------------------------------------------------------------------
module signed_int_to_utf8_script_digits (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [63:0] value,
	input  logic               use_superscript,
	input  logic               show_zero,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic               last
);

	localparam int VW = si2u8_pkg::VALUE_WIDTH;
	localparam int ND = si2u8_pkg::NUM_DIGITS;
	localparam int DCW = si2u8_pkg::DIGIT_CNT_W;
	localparam int BCW = si2u8_pkg::BIT_CNT_W;

	si2u8_pkg::state_t      state_q, state_d;
	si2u8_pkg::chain_ctrl_t ctrl;

	logic [VW-1:0]  value_low;
	logic           value_neg;
	logic [VW-1:0]  mag_next;
	logic [VW-1:0]  mag_q;
	logic [BCW-1:0] bit_cnt_q;
	logic [DCW-1:0] rem_q;
	logic [1:0]     pos_q;
	logic           neg_q;
	logic           sup_q;
	logic [3:0]     top_digit;
	logic           in_take;
	logic           slot_free;
	logic           produce;
	logic           is_minus;
	logic [1:0]     len;
	logic           glyph_end;
	logic           out_valid_q;
	logic [7:0]     out_byte_q;
	logic           last_q;

	// Only the low VALUE_WIDTH bits count, as a two's complement number.
	assign value_low = value[VW-1:0];
	assign value_neg = value_low[VW-1];
	assign mag_next = value_neg ? VW'(~value_low + VW'(1)) : value_low;

	assign in_stall = (state_q != si2u8_pkg::ST_IDLE);
	assign in_take = in_valid && !in_stall;

	assign slot_free = !out_valid_q || !out_stall;
	assign is_minus = (state_q == si2u8_pkg::ST_SIGN);
	assign produce = slot_free &&
		(state_q == si2u8_pkg::ST_SIGN || state_q == si2u8_pkg::ST_DIGIT);
	assign len = si2u8_pkg::glyph_len(is_minus, top_digit, sup_q);
	assign glyph_end = (pos_q == len - 2'd1);

	si2u8_digit_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.bit_in    (mag_q[VW-1]),
		.top_digit (top_digit)
	);

	// Next state and chain control.
	always_comb begin
		state_d = state_q;
		ctrl = '0;
		case (state_q)
			si2u8_pkg::ST_IDLE: begin
				if (in_take) begin
					ctrl.clear = 1'b1;
					// A zero value renders only when show_zero is set.
					if (value_low != '0 || show_zero) begin
						state_d = si2u8_pkg::ST_CONVERT;
					end
				end
			end
			si2u8_pkg::ST_CONVERT: begin
				ctrl.dabble = 1'b1;
				if (bit_cnt_q == '0) begin
					state_d = si2u8_pkg::ST_SKIP;
				end
			end
			si2u8_pkg::ST_SKIP: begin
				// Drop leading zeros but always keep the units digit.
				if (top_digit == 4'd0 && rem_q > DCW'(1)) begin
					ctrl.advance = 1'b1;
				end else begin
					state_d = neg_q ? si2u8_pkg::ST_SIGN : si2u8_pkg::ST_DIGIT;
				end
			end
			si2u8_pkg::ST_SIGN: begin
				if (produce && glyph_end) begin
					state_d = si2u8_pkg::ST_DIGIT;
				end
			end
			si2u8_pkg::ST_DIGIT: begin
				if (produce && glyph_end) begin
					ctrl.advance = 1'b1;
					if (rem_q == DCW'(1)) begin
						state_d = si2u8_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = si2u8_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= si2u8_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Magnitude shifter, counters and per-word flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			rem_q <= '0;
			pos_q <= 2'd0;
			neg_q <= 1'b0;
			sup_q <= 1'b0;
		end else begin
			if (in_take) begin
				bit_cnt_q <= BCW'(VW - 1);
				rem_q <= DCW'(ND);
				pos_q <= 2'd0;
				neg_q <= value_neg;
				sup_q <= use_superscript;
			end else if (state_q == si2u8_pkg::ST_CONVERT) begin
				bit_cnt_q <= bit_cnt_q - BCW'(1);
			end else if (state_q == si2u8_pkg::ST_SKIP && ctrl.advance) begin
				rem_q <= rem_q - DCW'(1);
			end else if (produce) begin
				if (glyph_end) begin
					pos_q <= 2'd0;
					if (state_q == si2u8_pkg::ST_DIGIT) begin
						rem_q <= rem_q - DCW'(1);
					end
				end else begin
					pos_q <= pos_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mag_q <= mag_next;
		end else if (state_q == si2u8_pkg::ST_CONVERT) begin
			mag_q <= {mag_q[VW-2:0], 1'b0};
		end
	end

	// Output register: a new word loads whenever the slot is empty or taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= produce;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			out_byte_q <= si2u8_pkg::glyph_byte(is_minus, top_digit, sup_q, pos_q);
			last_q <= glyph_end && (state_q == si2u8_pkg::ST_DIGIT) && (rem_q == DCW'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign last = last_q;

`ifndef SYNTH
	// Bytes go out only while at least one digit is still owed.
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == si2u8_pkg::ST_SKIP || state_q == si2u8_pkg::ST_SIGN ||
		 state_q == si2u8_pkg::ST_DIGIT) |-> (rem_q != '0))
		else $error("digit count ran out while rendering");

	// The byte position never passes the end of the current glyph.
	a_pos_in_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == si2u8_pkg::ST_SIGN || state_q == si2u8_pkg::ST_DIGIT) |->
		(pos_q < len))
		else $error("byte position beyond glyph length");

	// A hidden zero frees the input again at once.
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && value[VW-1:0] == '0 && !show_zero) |=>
		(state_q == si2u8_pkg::ST_IDLE))
		else $error("hidden zero started a rendering");
`endif

endmodule

// ===== bench/tb_signed_int_to_utf8_script_digits.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_utf8_script_digits: self-checking bench for the renderer.
// A queue of pending requests feeds a clocked sender, and a clocked receiver
// compares every output word with the UTF-8 bytes that a local predictor
// expects. Directed values cover zero with and without show_zero, every digit
// in both scripts, the signed extremes and minus one. Random values follow,
// with random idling on both channels, a long hold-off at the receiver and
// sender pauses that let the block drain completely.
// ----------------------------------------------------------------------------
module tb_signed_int_to_utf8_script_digits;

	localparam int RANDOM_WORDS = 450;
	localparam int CYCLE_LIMIT = 1000000;
	// Idle cycles after the last expected byte before the final verdict.
	localparam int SETTLE_CYCLES = 200;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int IDLE_PERCENT = 31;

	// UTF-8 bytes of the script glyphs.
	localparam logic [7:0] UTF8_LEAD3 = 8'hE2;
	localparam logic [7:0] UTF8_LEAD2 = 8'hC2;
	localparam logic [7:0] UTF8_SUP_PAGE = 8'h81;
	localparam logic [7:0] UTF8_SUB_PAGE = 8'h82;
	localparam logic [7:0] UTF8_SUP_ZERO = 8'hB0;
	localparam logic [7:0] UTF8_SUB_ZERO = 8'h80;
	localparam logic [7:0] UTF8_SUP_ONE = 8'hB9;
	localparam logic [7:0] UTF8_SUP_MINUS = 8'hBB;
	localparam logic [7:0] UTF8_SUB_MINUS = 8'h8B;

	// One value waiting to be offered. A drain request is held back until
	// every byte expected so far has left the block.
	typedef struct {
		logic signed [63:0] value;
		logic sup;
		logic zshow;
		logic drain;
	} script_req_t;

	// One expected output word.
	typedef struct {
		logic [7:0] code;
		logic last;
	} utf8_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [63:0] value = '0;
	logic use_superscript = 1'b0;
	logic show_zero = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_byte;
	logic last;

	script_req_t req_q[$];
	utf8_word_t glyph_bytes_q[$];
	int words_taken = 0;
	int total_words = 0;
	int mismatch_cnt = 0;
	int cycle_cnt = 0;
	logic hold_off = 1'b0;
	logic calm;

	// For a stretch of the run neither side idles, so back-to-back words
	// meet the block at full rate.
	assign calm = (words_taken >= 100) && (words_taken < 160);

	signed_int_to_utf8_script_digits dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.value           (value),
		.use_superscript (use_superscript),
		.show_zero       (show_zero),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_byte        (out_byte),
		.last            (last)
	);

	always #10 clk = ~clk;

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t ns: mismatch on %s, got %h, expected %h", $time, what, got, want);
		mismatch_cnt++;
	endtask

	// Appends the bytes of one glyph, none of them marked last yet.
	function automatic void queue_glyph(input logic is_minus, input logic [3:0] d,
			input logic sup);
		if (is_minus) begin
			glyph_bytes_q.push_back('{UTF8_LEAD3, 1'b0});
			glyph_bytes_q.push_back('{sup ? UTF8_SUP_PAGE : UTF8_SUB_PAGE, 1'b0});
			glyph_bytes_q.push_back('{sup ? UTF8_SUP_MINUS : UTF8_SUB_MINUS, 1'b0});
		end else if (sup && (d == 4'd1 || d == 4'd2 || d == 4'd3)) begin
			// Superscript one, two and three live in the Latin-1 block.
			glyph_bytes_q.push_back('{UTF8_LEAD2, 1'b0});
			glyph_bytes_q.push_back('{(d == 4'd1) ? UTF8_SUP_ONE : UTF8_SUP_ZERO + d, 1'b0});
		end else begin
			glyph_bytes_q.push_back('{UTF8_LEAD3, 1'b0});
			glyph_bytes_q.push_back('{sup ? UTF8_SUP_PAGE : UTF8_SUB_PAGE, 1'b0});
			glyph_bytes_q.push_back('{(sup ? UTF8_SUP_ZERO : UTF8_SUB_ZERO) + d, 1'b0});
		end
	endfunction

	// Works out the whole byte string of one accepted value and queues it.
	function automatic void render_script_digits(input logic [63:0] raw_in,
			input logic sup, input logic zshow);
		logic [63:0] raw;
		logic [63:0] mask;
		logic [63:0] mag;
		logic neg;
		logic [3:0] digits[20];
		int nd;
		raw = raw_in;
		// Only the low VALUE_WIDTH bits count, read as two's complement.
		if (si2u8_pkg::VALUE_WIDTH < 64) begin
			mask = (64'd1 << si2u8_pkg::VALUE_WIDTH) - 64'd1;
			raw = raw & mask;
			if (raw[si2u8_pkg::VALUE_WIDTH-1]) begin
				raw = raw | ~mask;
			end
		end
		neg = raw[63];
		// Unsigned negation keeps the most negative value exact.
		mag = neg ? 64'd0 - raw : raw;
		if (mag == 64'd0) begin
			if (zshow) begin
				queue_glyph(1'b0, 4'd0, sup);
				glyph_bytes_q[glyph_bytes_q.size()-1].last = 1'b1;
			end
			return;
		end
		if (neg) begin
			queue_glyph(1'b1, 4'd0, sup);
		end
		nd = 0;
		while (mag != 64'd0) begin
			digits[nd] = 4'(mag % 64'd10);
			mag = mag / 64'd10;
			nd++;
		end
		while (nd > 0) begin
			nd--;
			queue_glyph(1'b0, digits[nd], sup);
		end
		glyph_bytes_q[glyph_bytes_q.size()-1].last = 1'b1;
	endfunction

	task automatic add_word(input logic signed [63:0] v, input logic sup,
			input logic zshow, input logic drain);
		req_q.push_back('{v, sup, zshow, drain});
	endtask

	// Sender: a presented word stays put while the block stalls it. Once it
	// is taken, its bytes are predicted and the next word may be offered.
	always @(posedge clk or negedge arst_n) begin : sender
		script_req_t nxt;
		logic offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
			use_superscript <= 1'b0;
			show_zero <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				render_script_digits(value, use_superscript, show_zero);
				words_taken++;
			end
			if (!(in_valid && in_stall)) begin
				offer = 1'b0;
				if (req_q.size() != 0) begin
					// A drain word waits until the output side has caught up.
					if (req_q[0].drain && glyph_bytes_q.size() != 0) begin
						offer = 1'b0;
					end else begin
						offer = calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
					end
				end
				if (offer) begin
					nxt = req_q.pop_front();
					in_valid <= 1'b1;
					value <= nxt.value;
					use_superscript <= nxt.sup;
					show_zero <= nxt.zshow;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each word taken against the oldest expected byte,
	// then decides whether to stall the next cycle.
	always @(posedge clk or negedge arst_n) begin : receiver
		utf8_word_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (glyph_bytes_q.size() == 0) begin
					report_mismatch("byte with no value pending", out_byte, 8'h00);
				end else begin
					want = glyph_bytes_q.pop_front();
					if (out_byte !== want.code) begin
						report_mismatch("out_byte", out_byte, want.code);
					end
					if (last !== want.last) begin
						report_mismatch("last", {7'd0, last}, {7'd0, want.last});
					end
				end
			end
			out_stall <= hold_off || (!calm && $urandom_range(0, 99) < IDLE_PERCENT);
		end
	end

	// Long receiver hold-off in the middle of the run: the block fills its
	// output, stops taking words and stalls the sender.
	initial begin
		while (words_taken < 200) begin
			@(posedge clk);
		end
		hold_off <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic signed [63:0] v;
		int kind;
		// Zero with and without show_zero, in both scripts.
		add_word(64'sd0, 1'b0, 1'b1, 1'b0);
		add_word(64'sd0, 1'b1, 1'b1, 1'b0);
		add_word(64'sd0, 1'b0, 1'b0, 1'b0);
		add_word(64'sd0, 1'b1, 1'b0, 1'b0);
		// Every digit, both signs, both scripts.
		add_word(64'sd1234567890, 1'b0, 1'b0, 1'b0);
		add_word(64'sd1234567890, 1'b1, 1'b0, 1'b0);
		add_word(-64'sd9876543210, 1'b0, 1'b1, 1'b0);
		add_word(-64'sd9876543210, 1'b1, 1'b1, 1'b0);
		// The short superscript glyphs on their own.
		add_word(64'sd1, 1'b1, 1'b0, 1'b0);
		add_word(64'sd2, 1'b1, 1'b1, 1'b0);
		add_word(-64'sd3, 1'b1, 1'b0, 1'b0);
		add_word(64'sd1, 1'b0, 1'b0, 1'b0);
		// Signed extremes: the most negative value gives the longest string.
		add_word({1'b0, {63{1'b1}}}, 1'b0, 1'b0, 1'b0);
		add_word({1'b0, {63{1'b1}}}, 1'b1, 1'b1, 1'b0);
		add_word({1'b1, 63'd0}, 1'b0, 1'b1, 1'b0);
		add_word({1'b1, 63'd0}, 1'b1, 1'b0, 1'b0);
		add_word(-64'sd1, 1'b0, 1'b0, 1'b0);
		add_word(-64'sd1, 1'b1, 1'b1, 1'b0);
		add_word(64'sd10, 1'b1, 1'b0, 1'b0);
		add_word(-64'sd100, 1'b0, 1'b0, 1'b0);
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				v = 64'sd0;
			end else if (kind < 30) begin
				v = $urandom_range(0, 1999);
			end else if (kind < 40) begin
				// Close to one of the two extremes.
				v = $urandom_range(0, 1) ? {1'b0, {63{1'b1}}} - $urandom_range(0, 20)
						: {1'b1, 63'd0} + $urandom_range(0, 20);
			end else begin
				v = {$urandom, $urandom};
			end
			if (kind >= 8 && kind < 30 && $urandom_range(0, 1)) begin
				v = -v;
			end
			// Twice the sender waits for the block to drain before going on.
			add_word(v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					i == 0 || i == 330);
		end
		total_words = req_q.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (words_taken < total_words) begin
			@(posedge clk);
		end
		while (glyph_bytes_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/si2u8_pkg.sv
design/si2u8_bcd_cell.sv
design/si2u8_digit_chain.sv
design/signed_int_to_utf8_script_digits.sv
bench/tb_signed_int_to_utf8_script_digits.sv
